### rtl/lfsc_pkg.sv
// ----------------------------------------------------------------------------
// lfsc_pkg
// shared types, character constants and keyword tables for the lease file
// shape checker
// ----------------------------------------------------------------------------
package lfsc_pkg;

  // character codes
  localparam logic [7:0] CH_NL       = 8'h0A;
  localparam logic [7:0] CH_TAB      = 8'h09;
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_PRINT_LO = 8'h20;
  localparam logic [7:0] CH_PRINT_HI = 8'h7E;
  localparam logic [7:0] CH_ZERO     = 8'h30;
  localparam logic [7:0] CH_NINE     = 8'h39;

  // token length bookkeeping
  localparam int unsigned TOK_LEN_W  = 4;
  localparam logic [TOK_LEN_W-1:0] LEN_SAT    = 4'd12;
  localparam logic [TOK_LEN_W-1:0] LEN_DUID   = 4'd4;
  localparam logic [TOK_LEN_W-1:0] LEN_VENDOR = 4'd11;
  localparam logic [TOK_LEN_W-1:0] LEN_AGENT  = 4'd10;

  // keyword candidate bits
  localparam int unsigned KW_DUID   = 0;
  localparam int unsigned KW_VENDOR = 1;
  localparam int unsigned KW_AGENT  = 2;
  localparam int unsigned KW_NUM    = 3;

  typedef enum logic [2:0] {
    PH_LEAD  = 3'b001,
    PH_TOKEN = 3'b010,
    PH_REST  = 3'b100
  } lfsc_phase_t;

  typedef struct packed {
    lfsc_phase_t          phase;
    logic [TOK_LEN_W-1:0] tok_len;
    logic                 all_digits;
    logic [KW_NUM-1:0]    cand;
  } lfsc_line_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_marker;
  } lfsc_item_t;

  typedef struct packed {
    logic valid;
    logic file_valid;
  } lfsc_verdict_t;

  localparam lfsc_line_t LINE_CLEAR = '{
    phase:      PH_LEAD,
    tok_len:    '0,
    all_digits: 1'b1,
    cand:       {KW_NUM{1'b1}}
  };

  // keyword characters by position
  function automatic logic [7:0] duid_char(input logic [TOK_LEN_W-1:0] idx);
    logic [7:0] c;
    unique case (idx)
      4'd0:    c = "d";
      4'd1:    c = "u";
      4'd2:    c = "i";
      4'd3:    c = "d";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] vendor_char(input logic [TOK_LEN_W-1:0] idx);
    logic [7:0] c;
    unique case (idx)
      4'd0:    c = "v";
      4'd1:    c = "e";
      4'd2:    c = "n";
      4'd3:    c = "d";
      4'd4:    c = "o";
      4'd5:    c = "r";
      4'd6:    c = "c";
      4'd7:    c = "l";
      4'd8:    c = "a";
      4'd9:    c = "s";
      4'd10:   c = "s";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] agent_char(input logic [TOK_LEN_W-1:0] idx);
    logic [7:0] c;
    unique case (idx)
      4'd0:    c = "a";
      4'd1:    c = "g";
      4'd2:    c = "e";
      4'd3:    c = "n";
      4'd4:    c = "t";
      4'd5:    c = "-";
      4'd6:    c = "i";
      4'd7:    c = "n";
      4'd8:    c = "f";
      4'd9:    c = "o";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

### rtl/lfsc_ifs.sv
// ----------------------------------------------------------------------------
// lfsc channel interfaces
// valid/ready channels for the byte stream and the verdict
// ----------------------------------------------------------------------------
interface lfsc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_marker;

  modport source (output valid, data_byte, end_marker, input ready);
  modport sink   (input valid, data_byte, end_marker, output ready);
endinterface

interface lfsc_out_if;
  logic valid;
  logic ready;
  logic file_valid;

  modport source (output valid, file_valid, input ready);
  modport sink   (input valid, file_valid, output ready);
endinterface

### rtl/lfsc_in_stage.sv
// ----------------------------------------------------------------------------
// lfsc_in_stage
// input register holding one byte or end-of-file transaction
// ----------------------------------------------------------------------------
module lfsc_in_stage import lfsc_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  lfsc_in_if.sink       in_chan,
  input  logic          go,
  output logic          item_valid,
  output lfsc_item_t    item
);

  logic       valid_r;
  lfsc_item_t item_r;
  logic       fire;

  assign in_chan.ready = !valid_r || go;
  assign fire          = in_chan.valid && in_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (fire) begin
      valid_r <= 1'b1;
    end else if (go) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      item_r.data_byte  <= in_chan.data_byte;
      item_r.end_marker <= in_chan.end_marker;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

### rtl/lfsc_scan.sv
// ----------------------------------------------------------------------------
// lfsc_scan
// line state and sticky failure flag, updated once per transaction
// ----------------------------------------------------------------------------
module lfsc_scan import lfsc_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          go,
  input  lfsc_item_t    item,
  output lfsc_verdict_t verdict
);

  lfsc_line_t        line_r, line_nxt;
  logic              failed_r, failed_nxt;
  lfsc_line_t        took;
  logic [7:0]        b;
  logic              in_token;
  logic              judge_ok;
  logic              blank;
  logic              bad_char;
  logic              is_digit;
  logic [KW_NUM-1:0] hit;

  assign b        = item.data_byte;
  assign in_token = (line_r.phase == PH_TOKEN);
  assign blank    = (b == CH_SPACE) || (b == CH_TAB);
  assign bad_char = (b != CH_TAB) && ((b < CH_PRINT_LO) || (b > CH_PRINT_HI));
  assign is_digit = (b >= CH_ZERO) && (b <= CH_NINE);

  // token passes as a number or as one of the keywords
  assign judge_ok = line_r.all_digits
                 || (line_r.cand[KW_DUID]   && (line_r.tok_len == LEN_DUID))
                 || (line_r.cand[KW_VENDOR] && (line_r.tok_len == LEN_VENDOR))
                 || (line_r.cand[KW_AGENT]  && (line_r.tok_len == LEN_AGENT));

  // keyword prefix match at the current position
  assign hit[KW_DUID]   = (line_r.tok_len < LEN_DUID)   && (duid_char(line_r.tok_len) == b);
  assign hit[KW_VENDOR] = (line_r.tok_len < LEN_VENDOR) && (vendor_char(line_r.tok_len) == b);
  assign hit[KW_AGENT]  = (line_r.tok_len < LEN_AGENT)  && (agent_char(line_r.tok_len) == b);

  always_comb begin
    took            = line_r;
    took.phase      = PH_TOKEN;
    took.all_digits = line_r.all_digits && is_digit;
    took.cand       = line_r.cand & hit;
    if (line_r.tok_len < LEN_SAT) begin
      took.tok_len = line_r.tok_len + 4'd1;
    end
  end

  always_comb begin
    line_nxt   = line_r;
    failed_nxt = failed_r;
    if (item.end_marker) begin
      line_nxt   = LINE_CLEAR;
      failed_nxt = 1'b0;
    end else if (b == CH_NL) begin
      if (in_token && !judge_ok) begin
        failed_nxt = 1'b1;
      end
      line_nxt = LINE_CLEAR;
    end else begin
      if (bad_char) begin
        failed_nxt = 1'b1;
      end
      unique case (line_r.phase)
        PH_LEAD: begin
          if (!blank) begin
            line_nxt = took;
          end
        end
        PH_TOKEN: begin
          if (blank) begin
            if (!judge_ok) begin
              failed_nxt = 1'b1;
            end
            line_nxt.phase = PH_REST;
          end else begin
            line_nxt = took;
          end
        end
        PH_REST: begin
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_r   <= LINE_CLEAR;
      failed_r <= 1'b0;
    end else if (go) begin
      line_r   <= line_nxt;
      failed_r <= failed_nxt;
    end
  end

  assign verdict.valid      = go && item.end_marker;
  assign verdict.file_valid = !(failed_r || (in_token && !judge_ok));

endmodule

### rtl/lfsc_out_stage.sv
// ----------------------------------------------------------------------------
// lfsc_out_stage
// result register driving the verdict channel
// ----------------------------------------------------------------------------
module lfsc_out_stage import lfsc_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  lfsc_verdict_t verdict,
  output logic          out_free,
  lfsc_out_if.source    out_chan
);

  logic valid_r;
  logic file_valid_r;

  assign out_free = !valid_r || out_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (verdict.valid) begin
      valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (verdict.valid) begin
      file_valid_r <= verdict.file_valid;
    end
  end

  assign out_chan.valid      = valid_r;
  assign out_chan.file_valid = file_valid_r;

endmodule

### rtl/lease_file_shape_checker.sv
// ----------------------------------------------------------------------------
// lease_file_shape_checker
// byte-stream checker for the shape of a lease file
// ----------------------------------------------------------------------------
// usage:
//   in_chan carries one transaction per file byte (data_byte, end_marker = 0)
//   and one end-of-file transaction (end_marker = 1) that closes the file
//   out_chan carries one file_valid verdict per end-of-file transaction,
//   data bytes give no result
// timing:
//   one transaction accepted per cycle, sustained, for bytes and end marks,
//   unless an end mark is held by a verdict waiting on out_chan (see stall);
//   a transaction is scanned while in the input register, and the verdict
//   is registered in the result register as the end mark leaves it
// reset:
//   synchronous active-low rst_n empties both registers and clears the line
//   state, so a file may start right after reset; an empty file is valid
// stall:
//   while a verdict waits on out_chan, data bytes still flow; an end mark
//   waits in the input register until the result register frees up, and
//   in_chan.ready drops only then
// ----------------------------------------------------------------------------
module lease_file_shape_checker import lfsc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  lfsc_in_if.sink    in_chan,
  lfsc_out_if.source out_chan
);

  logic          s1_valid;
  lfsc_item_t    s1_item;
  logic          out_free;
  logic          go;
  lfsc_verdict_t verdict;

  // a byte always advances; an end mark needs room in the result register
  assign go = s1_valid && (!s1_item.end_marker || out_free);

  lfsc_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .go         (go),
    .item_valid (s1_valid),
    .item       (s1_item)
  );

  // line phase, token tracking and sticky failure
  lfsc_scan u_scan (
    .clk     (clk),
    .rst_n   (rst_n),
    .go      (go),
    .item    (s1_item),
    .verdict (verdict)
  );

  lfsc_out_stage u_out_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .verdict  (verdict),
    .out_free (out_free),
    .out_chan (out_chan)
  );

endmodule

### rtl/lfsc_checker.sv
// ----------------------------------------------------------------------------
// lfsc_checker
// port-level assertions for the lease file shape checker
// ----------------------------------------------------------------------------
module lfsc_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic in_end_marker,
  input logic out_valid,
  input logic out_ready,
  input logic out_file_valid
);

  logic [1:0] pending_r;
  logic       end_in;
  logic       res_out;

  assign end_in  = in_valid && in_ready && in_end_marker;
  assign res_out = out_valid && out_ready;

  // end marks accepted whose verdict is not yet taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= 2'd0;
    end else begin
      pending_r <= pending_r + {1'b0, end_in} - {1'b0, res_out};
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("verdict dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_file_valid))
    else $error("verdict changed while stalled");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pending_r != 2'd0)
    else $error("verdict without end-of-file transaction");

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    pending_r == 2'd0 |-> in_ready)
    else $error("input stalled with no verdict outstanding");

  a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    pending_r != 2'd3)
    else $error("too many verdicts outstanding");

endmodule

bind lease_file_shape_checker lfsc_checker u_lfsc_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_chan.valid),
  .in_ready       (in_chan.ready),
  .in_end_marker  (in_chan.end_marker),
  .out_valid      (out_chan.valid),
  .out_ready      (out_chan.ready),
  .out_file_valid (out_chan.file_valid)
);

### test/lease_file_shape_checker_tb.sv
// ----------------------------------------------------------------------------
// lease_file_shape_checker_tb
// drives byte streams of lease files into the checker through the valid/ready
// input channel, predicts each end-of-file verdict with an independent line
// scanner and compares it with every verdict taken from the result channel
// ----------------------------------------------------------------------------
module lease_file_shape_checker_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lfsc_pkg::*;

  // --------------------------------------------------------------------------
  // verdict scoreboard: scans accepted bytes line by line and queues the
  // verdict that each end-of-file transaction must produce
  // --------------------------------------------------------------------------
  class lease_verdict_board;
    string                keyword [KW_NUM];
    lfsc_phase_t          phase;
    logic [TOK_LEN_W-1:0] tok_len;
    logic                 all_digits;
    logic [KW_NUM-1:0]    cand;
    logic                 failed;
    logic                 verdict_q[$];
    int                   mismatches;

    function new();
      keyword[KW_DUID]   = "duid";
      keyword[KW_VENDOR] = "vendorclass";
      keyword[KW_AGENT]  = "agent-info";
      mismatches = 0;
      restart_file();
    endfunction

    function void restart_line();
      phase      = PH_LEAD;
      tok_len    = '0;
      all_digits = 1'b1;
      cand       = '1;
    endfunction

    function void restart_file();
      restart_line();
      failed = 1'b0;
    endfunction

    // a token passes as all digits or as one whole keyword
    function void judge_token();
      logic ok;
      ok = all_digits
        || (cand[KW_DUID]   && tok_len == LEN_DUID)
        || (cand[KW_VENDOR] && tok_len == LEN_VENDOR)
        || (cand[KW_AGENT]  && tok_len == LEN_AGENT);
      if (!ok) failed = 1'b1;
    endfunction

    function void take_token_byte(logic [7:0] b);
      int pos;
      int k;
      pos = tok_len;
      if (b < CH_ZERO || b > CH_NINE) all_digits = 1'b0;
      for (k = 0; k < KW_NUM; k++) begin
        if (!(pos < keyword[k].len() && 8'(keyword[k][pos]) == b)) cand[k] = 1'b0;
      end
      if (tok_len < LEN_SAT) tok_len = tok_len + 1'b1;
    endfunction

    function void note_input(logic [7:0] b, logic eof);
      logic blank;
      blank = (b == CH_SPACE || b == CH_TAB);
      if (eof) begin
        // data byte of the end transaction is ignored
        if (phase == PH_TOKEN) judge_token();
        verdict_q.push_back(!failed);
        restart_file();
      end else if (b == CH_NL) begin
        if (phase == PH_TOKEN) judge_token();
        restart_line();
      end else begin
        if (b != CH_TAB && (b < CH_PRINT_LO || b > CH_PRINT_HI)) failed = 1'b1;
        case (phase)
          PH_LEAD: begin
            if (!blank) begin
              phase = PH_TOKEN;
              take_token_byte(b);
            end
          end
          PH_TOKEN: begin
            if (blank) begin
              judge_token();
              phase = PH_REST;
            end else begin
              take_token_byte(b);
            end
          end
          default: ;
        endcase
      end
    endfunction

    function void check_verdict(logic fv);
      logic want;
      if (verdict_q.size() == 0) begin
        $display("%0t ns: verdict without end of file, expected none, actual %0b",
                 $time, fv);
        mismatches++;
      end else begin
        want = verdict_q.pop_front();
        if (fv !== want) begin
          $display("%0t ns: file_valid mismatch, expected %0b, actual %0b",
                   $time, want, fv);
          mismatches++;
        end
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // clock, reset, channels and the block
  // --------------------------------------------------------------------------
  logic clk;
  logic rst_n;

  lfsc_in_if  in_chan ();
  lfsc_out_if out_chan ();

  lease_file_shape_checker dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  lease_verdict_board sb = new();

  // shared stimulus controls
  bit         idle_on;        // random gaps on both sides when set
  int         hold_request;   // long receiver hold-off, in cycles
  int         sent_count;     // accepted input transactions so far
  logic [7:0] file_buf[$];    // bytes of the file being sent

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // absolute limit on the run
  initial begin
    #2ms;
    $display("tb: failure");
    $finish;
  end

  // --------------------------------------------------------------------------
  // monitors: transactions sampled at the rising edge on both channels
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && in_chan.valid && in_chan.ready)
      sb.note_input(in_chan.data_byte, in_chan.end_marker);
    if (rst_n && out_chan.valid && out_chan.ready)
      sb.check_verdict(out_chan.file_valid);
  end

  // --------------------------------------------------------------------------
  // verdict receiver: random wait before each verdict while idle_on is set, plus the long hold-off
  // that lets the block fill up and stall its input
  // --------------------------------------------------------------------------
  initial begin : verdict_sink
    int wait_left;
    bit took;
    wait_left = 0;
    took = 1'b1;
    out_chan.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        wait_left = hold_request;
        hold_request = 0;
      end else if (took) begin
        wait_left = idle_on ? $urandom_range(0, 6) : 0;
        took = 1'b0;
      end
      if (wait_left > 0) begin
        out_chan.ready <= 1'b0;
        wait_left--;
      end else begin
        out_chan.ready <= 1'b1;
      end
      @(posedge clk);
      took = out_chan.valid && out_chan.ready;
    end
  end

  // --------------------------------------------------------------------------
  // sender tasks; each starts and ends at a falling edge
  // --------------------------------------------------------------------------
  task automatic send_item(input logic [7:0] b, input logic eof);
    int gap;
    gap = idle_on ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_chan.valid      <= 1'b1;
    in_chan.data_byte  <= b;
    in_chan.end_marker <= eof;
    do @(posedge clk); while (!in_chan.ready);
    sent_count++;
    @(negedge clk);
  endtask

  // all bytes of file_buf, then the end-of-file transaction
  task automatic send_file(input logic [7:0] eof_byte);
    foreach (file_buf[i]) send_item(file_buf[i], 1'b0);
    send_item(eof_byte, 1'b1);
    file_buf.delete();
  endtask

  // stop offering and wait until every expected verdict has been taken
  task automatic wait_drained();
    in_chan.valid <= 1'b0;
    @(negedge clk);
    while (sb.verdict_q.size() != 0) @(negedge clk);
  endtask

  // --------------------------------------------------------------------------
  // file builders
  // --------------------------------------------------------------------------
  function automatic void push_text(string s);
    int i;
    for (i = 0; i < s.len(); i++) file_buf.push_back(8'(s[i]));
  endfunction

  function automatic logic [7:0] rand_blank();
    return $urandom_range(0, 1) ? CH_SPACE : CH_TAB;
  endfunction

  // printable, never a blank
  function automatic logic [7:0] rand_print();
    return 8'($urandom_range(CH_PRINT_LO + 1, CH_PRINT_HI));
  endfunction

  function automatic void build_line(bit last);
    int    kind;
    int    mode;
    int    n;
    int    i;
    string word;
    kind = $urandom_range(0, 9);
    repeat ($urandom_range(0, 2)) file_buf.push_back(rand_blank());
    case (kind)
      0: ;  // empty or blank-only line
      1: begin
        repeat ($urandom_range(1, 3)) file_buf.push_back(rand_blank());
      end
      2, 3: begin
        // digit tokens, some past the length where the counter saturates
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 15) : $urandom_range(1, 6);
        repeat (n) file_buf.push_back(8'($urandom_range(CH_ZERO, CH_NINE)));
      end
      4, 5, 6: begin
        push_text(sb.keyword[$urandom_range(0, KW_NUM - 1)]);
      end
      7: begin
        // keyword cut short, extended by one byte or with one byte changed
        word = sb.keyword[$urandom_range(0, KW_NUM - 1)];
        mode = $urandom_range(0, 2);
        if (mode == 0) word = word.substr(0, $urandom_range(0, word.len() - 2));
        if (mode == 2) begin
          i = $urandom_range(0, word.len() - 1);
          word[i] = rand_print();
        end
        push_text(word);
        if (mode == 1) file_buf.push_back(rand_print());
      end
      8: begin
        repeat ($urandom_range(1, 5)) file_buf.push_back(rand_print());
      end
      default: begin
        repeat ($urandom_range(1, 4)) file_buf.push_back(8'($urandom_range(0, 255)));
      end
    endcase
    // rest of line after a blank, checked only for non-printable bytes
    if (kind >= 2 && $urandom_range(0, 1)) begin
      file_buf.push_back(rand_blank());
      repeat ($urandom_range(0, 6)) file_buf.push_back(8'($urandom_range(CH_PRINT_LO, CH_PRINT_HI)));
    end
    // last line may end at end of file without a newline
    if (!last || $urandom_range(0, 1)) file_buf.push_back(CH_NL);
  endfunction

  function automatic void build_file();
    int lines;
    int l;
    lines = $urandom_range(0, 4);
    for (l = 0; l < lines; l++) build_line(l == lines - 1);
    // occasional stray byte inserted before a random byte of the file
    if (file_buf.size() > 0 && $urandom_range(0, 7) == 0)
      file_buf.insert($urandom_range(0, file_buf.size() - 1), 8'($urandom_range(0, 255)));
  endfunction

  // --------------------------------------------------------------------------
  // main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_n = 1'b0;
    in_chan.valid = 1'b0;
    in_chan.data_byte = '0;
    in_chan.end_marker = 1'b0;
    idle_on = 1'b1;
    hold_request = 0;
    sent_count = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed files
    send_file(8'hFF);                        // empty file, end byte ignored
    push_text("duid");                       // token closed by end of file
    send_file(8'h00);
    file_buf = '{CH_SPACE, CH_TAB, CH_NL};   // blank-only line
    send_file(8'h5A);
    file_buf = '{8'h00};                     // nul byte
    send_file(8'h00);
    push_text("7");                          // carriage return
    file_buf.push_back(8'h0D);
    send_file(8'h00);
    push_text("4 ~");                        // 0x7f in the rest of a line
    file_buf.push_back(8'h7F);
    send_file(8'h01);
    file_buf = '{8'hFF};                     // top byte value
    send_file(8'h80);
    push_text("3 ");                         // control byte just below space
    file_buf.push_back(8'h1F);
    send_file(8'h00);

    // back pressure: receiver holds off while short files stream in
    // back to back, then the sender waits for every verdict
    idle_on = 1'b0;
    hold_request = 150;
    repeat (8) begin
      push_text("5\n");
      send_file(8'h00);
    end
    wait_drained();

    // random files, with stretches of no idling on either side
    while (sent_count < 1350) begin
      idle_on = ($urandom_range(0, 3) != 0);
      build_file();
      send_file(8'($urandom_range(0, 255)));
      if ($urandom_range(0, 9) == 0) wait_drained();
    end

    wait_drained();
    // let the clock run on to catch any stray verdict
    repeat (8) @(posedge clk);
    @(negedge clk);
    if (sb.mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### files.f
rtl/lfsc_pkg.sv
rtl/lfsc_ifs.sv
rtl/lfsc_in_stage.sv
rtl/lfsc_scan.sv
rtl/lfsc_out_stage.sv
rtl/lease_file_shape_checker.sv
rtl/lfsc_checker.sv
test/lease_file_shape_checker_tb.sv
